@@ rtl/array_priority_queue_macros.svh @@
`ifndef ARRAY_PRIORITY_QUEUE_MACROS_SVH
`define ARRAY_PRIORITY_QUEUE_MACROS_SVH

// same-cycle implication, sampled on clk, off while rst is high
`define APQ_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, sampled on clk, off while rst is high
`define APQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/apq_pkg.sv @@
package apq_pkg;

  localparam int DEPTH = 32;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = $clog2(DEPTH + 1);
  localparam int LIM_W = 6;
  localparam int VAL_W = 32;
  localparam int PRI_W = 8;
  localparam int CMP_W = (CW > LIM_W) ? CW : LIM_W;

  localparam logic [LIM_W-1:0] LIMIT_RESET = LIM_W'(32);

  typedef enum logic [1:0] {
    ST_INSERTED = 2'd0,
    ST_REMOVED  = 2'd1,
    ST_FULL     = 2'd2,
    ST_EMPTY    = 2'd3
  } apq_status_t;

  typedef struct packed {
    logic [PRI_W-1:0] pri;
    logic [VAL_W-1:0] val;
  } apq_entry_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic insert;
    logic refuse_empty;
    logic scan_step;
    logic prep_shift;
    logic shift_step;
    logic commit;
    logic finish;
  } apq_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_remove;
    logic empty_now;
    logic scan_more;
    logic shift_more;
  } apq_sts_t;

endpackage

@@ rtl/apq_dp.sv @@
`include "array_priority_queue_macros.svh"

module apq_dp (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write,
  input  logic [apq_pkg::LIM_W-1:0]       cfg_data,
  input  logic                            kind,
  input  logic signed [apq_pkg::VAL_W-1:0] new_value,
  input  logic [apq_pkg::PRI_W-1:0]       new_priority,
  input  apq_pkg::apq_cmd_t               cmd,
  output apq_pkg::apq_sts_t               sts,
  output logic [1:0]                      status,
  output logic signed [apq_pkg::VAL_W-1:0] removed_value,
  output logic [apq_pkg::LIM_W-1:0]       entry_count,
  output logic                            is_full,
  output logic                            queue_empty
);

  localparam int AW    = apq_pkg::AW;
  localparam int CW    = apq_pkg::CW;
  localparam int CMP_W = apq_pkg::CMP_W;
  localparam int LIM_W = apq_pkg::LIM_W;
  localparam int VAL_W = apq_pkg::VAL_W;
  localparam int PRI_W = apq_pkg::PRI_W;

  apq_pkg::apq_entry_t mem [apq_pkg::DEPTH];

  logic                 op_remove;
  apq_pkg::apq_entry_t  op_entry;
  logic [CW-1:0]        occ;
  logic [LIM_W-1:0]     lim;
  logic [CW-1:0]        idx;
  logic                 pend_cmp;
  logic                 pend_wr;
  logic [AW-1:0]        pend_idx;
  logic [AW-1:0]        best_idx;
  logic [PRI_W-1:0]     best_pri;
  logic [VAL_W-1:0]     best_val;
  apq_pkg::apq_entry_t  rd_data;
  apq_pkg::apq_status_t res_status;
  logic [VAL_W-1:0]     res_value;

  logic [CW-1:0]        idx_inc;
  logic [CMP_W-1:0]     lim_ext;
  logic [CMP_W-1:0]     depth_ext;
  logic [CMP_W-1:0]     lim_eff;
  logic [CMP_W-1:0]     occ_ext;
  logic                 full_now;
  logic                 ins_ok;
  logic                 we;
  logic [AW-1:0]        waddr;
  apq_pkg::apq_entry_t  wdata;
  logic [AW-1:0]        raddr;

  assign idx_inc   = idx + CW'(1);
  assign lim_ext   = CMP_W'(lim);
  assign depth_ext = CMP_W'(apq_pkg::DEPTH);
  assign lim_eff   = (lim_ext > depth_ext) ? depth_ext : lim_ext;
  assign occ_ext   = CMP_W'(occ);
  assign full_now  = (occ_ext >= lim_eff);
  assign ins_ok    = cmd.insert && !full_now;

  assign sts.is_remove  = op_remove;
  assign sts.empty_now  = (occ == '0);
  assign sts.scan_more  = (idx < occ);
  assign sts.shift_more = (idx_inc < occ);

  // scan reads entry idx, shift reads the entry above idx
  assign raddr = cmd.scan_step ? idx[AW-1:0] : idx_inc[AW-1:0];

  always_comb begin
    we    = 1'b0;
    waddr = occ[AW-1:0];
    wdata = op_entry;
    if (pend_wr) begin
      we    = 1'b1;
      waddr = pend_idx;
      wdata = rd_data;
    end else if (cmd.insert && !full_now) begin
      we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_data <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      occ      <= '0;
      lim      <= apq_pkg::LIMIT_RESET;
      pend_cmp <= 1'b0;
      pend_wr  <= 1'b0;
    end else begin
      if (cfg_write) begin
        lim <= cfg_data;
      end
      pend_cmp <= cmd.scan_step;
      pend_wr  <= cmd.shift_step;
      if (cmd.insert && !full_now) begin
        occ <= occ + CW'(1);
      end else if (cmd.commit) begin
        occ <= occ - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_remove    <= kind;
      op_entry.val <= new_value;
      op_entry.pri <= new_priority;
      idx          <= '0;
    end else if (cmd.scan_step || cmd.shift_step) begin
      pend_idx <= idx[AW-1:0];
      idx      <= idx_inc;
    end else if (cmd.prep_shift) begin
      idx <= CW'(best_idx);
    end

    // first entry seeds the best, later ones win only on strictly higher priority
    if (pend_cmp && ((pend_idx == '0) || (rd_data.pri > best_pri))) begin
      best_idx <= pend_idx;
      best_pri <= rd_data.pri;
      best_val <= rd_data.val;
    end

    if (cmd.insert) begin
      res_status <= full_now ? apq_pkg::ST_FULL : apq_pkg::ST_INSERTED;
      res_value  <= '0;
    end else if (cmd.refuse_empty) begin
      res_status <= apq_pkg::ST_EMPTY;
      res_value  <= '0;
    end else if (cmd.commit) begin
      res_status <= apq_pkg::ST_REMOVED;
      res_value  <= best_val;
    end

    if (cmd.finish) begin
      status        <= res_status;
      removed_value <= res_value;
      entry_count   <= occ_ext[LIM_W-1:0];
      is_full       <= full_now;
      queue_empty   <= (occ == '0);
    end
  end

  `APQ_ASSERT_NOW(a_occ_bound, 1'b1, occ <= CW'(apq_pkg::DEPTH), "occupancy above depth")
  `APQ_ASSERT_NEXT(a_insert_grows, ins_ok, occ == $past(occ) + CW'(1), "insert did not grow count")
  `APQ_ASSERT_NEXT(a_commit_shrinks, cmd.commit, occ == $past(occ) - CW'(1), "no shrink on remove")

endmodule

@@ rtl/apq_ctrl.sv @@
module apq_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  input  apq_pkg::apq_sts_t sts,
  output apq_pkg::apq_cmd_t cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_SCAN,
    S_SCAN_WAIT,
    S_PREP,
    S_SHIFT,
    S_SHIFT_WAIT,
    S_FIN
  } state_t;

  state_t state;
  logic   out_free;

  assign in_stall = (state != S_IDLE);
  assign out_free = !out_valid || !out_stall;

  always_comb begin
    cmd = '0;
    case (state)
      S_IDLE:       cmd.load = in_valid;
      S_EXEC: begin
        cmd.insert       = !sts.is_remove;
        cmd.refuse_empty = sts.is_remove && sts.empty_now;
      end
      S_SCAN:       cmd.scan_step = sts.scan_more;
      S_SCAN_WAIT:  cmd = '0;
      S_PREP:       cmd.prep_shift = 1'b1;
      S_SHIFT:      cmd.shift_step = sts.shift_more;
      S_SHIFT_WAIT: cmd.commit = 1'b1;
      S_FIN:        cmd.finish = out_free;
      default:      cmd = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (!sts.is_remove || sts.empty_now) begin
            state <= S_FIN;
          end else begin
            state <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (!sts.scan_more) begin
            state <= S_SCAN_WAIT;
          end
        end
        S_SCAN_WAIT:  state <= S_PREP;
        S_PREP:       state <= S_SHIFT;
        S_SHIFT: begin
          if (!sts.shift_more) begin
            state <= S_SHIFT_WAIT;
          end
        end
        S_SHIFT_WAIT: state <= S_FIN;
        S_FIN: begin
          if (out_free) begin
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default:      state <= S_IDLE;
      endcase
    end
  end

endmodule

@@ rtl/array_priority_queue.sv @@
// request path: an insert or a refused request goes from acceptance straight to the result
//   register; a remove scans all n entries, then shifts down the ones above the picked one
// flow: one request in flight; the next is taken in the cycle after its result is
//   registered, which waits on out_stall; one entry is read per scan and shift step
// reset (rst, synchronous, active high): queue empty, capacity_limit back to 32,
//   no result pending; entry memory keeps old contents and is never read before written
module array_priority_queue (
  input  logic                             clk,
  input  logic                             rst,
  // capacity_limit register write
  input  logic                             cfg_write,
  input  logic [apq_pkg::LIM_W-1:0]        cfg_data,
  // request channel
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic                             kind,
  input  logic signed [apq_pkg::VAL_W-1:0] new_value,
  input  logic [apq_pkg::PRI_W-1:0]        new_priority,
  // result channel
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [1:0]                       status,
  output logic signed [apq_pkg::VAL_W-1:0] removed_value,
  output logic [apq_pkg::LIM_W-1:0]        entry_count,
  output logic                             is_full,
  output logic                             queue_empty
);

  // command and status between the sequencer and the datapath
  apq_pkg::apq_cmd_t cmd;
  apq_pkg::apq_sts_t sts;

  // sequencer: accepts a request, walks the scan then the shift, and
  // hands the result to the output register once it is free; a new
  // request can be taken while the previous result still waits
  apq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  // datapath: entry memory in arrival order, count, limit, the running
  // best-priority pick (oldest wins ties) and the result registers
  apq_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .cfg_write     (cfg_write),
    .cfg_data      (cfg_data),
    .kind          (kind),
    .new_value     (new_value),
    .new_priority  (new_priority),
    .cmd           (cmd),
    .sts           (sts),
    .status        (status),
    .removed_value (removed_value),
    .entry_count   (entry_count),
    .is_full       (is_full),
    .queue_empty   (queue_empty)
  );

endmodule
